/* design/sgm_pkg.sv */
package sgm_pkg;

    // field widths
    localparam int PIXEL_W = 8;
    localparam int COORD_W = 10;
    localparam int GRAD_W  = 11;
    localparam int MAG_W   = 11;
    localparam int CFG_W   = 11;

    // square root unit: one result bit per step
    localparam int SQRT_STEPS = 11;
    localparam int RAD_W      = 2 * SQRT_STEPS - 1;
    localparam int RES_W      = RAD_W + 1;

    // frame geometry
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MIN_DIM       = 3;
    localparam int MAX_DIM       = 1024;
    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // per-result side information carried down the pipeline
    typedef struct packed {
        logic [COORD_W-1:0]       center_row;
        logic [COORD_W-1:0]       center_col;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     frame_last;
    } sgm_meta_t;

    // partial state of the digit-by-digit square root
    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RES_W-1:0] res;
    } sqrt_state_t;

    // one step of the square root: try the current bit, keep it if it fits
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [RES_W-1:0] bit_val);
        sqrt_state_t      nxt;
        logic [RES_W-1:0] trial;
        trial = st.res + bit_val;
        if ({1'b0, st.rem} >= trial)
        begin
            nxt.rem = st.rem - trial[RAD_W-1:0];
            nxt.res = (st.res >> 1) + bit_val;
        end
        else
        begin
            nxt.rem = st.rem;
            nxt.res = st.res >> 1;
        end
        return nxt;
    endfunction

endpackage

/* design/sgm_sqrt_pipe.sv */
module sgm_sqrt_pipe
    import sgm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] in_rad,
    input  sgm_meta_t        in_meta,
    output logic             out_valid,
    output logic [MAG_W-1:0] out_root,
    output sgm_meta_t        out_meta
);

    logic        valid_reg [SQRT_STEPS];
    sqrt_state_t st_reg    [SQRT_STEPS];
    sgm_meta_t   meta_reg  [SQRT_STEPS];
    sqrt_state_t st_next   [SQRT_STEPS];

    // one stage per result bit, highest bit first
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [RES_W-1:0] BIT_VAL = RES_W'(1) << (2 * (SQRT_STEPS - 1 - k));

        if (k == 0)
        begin : g_first
            sqrt_state_t st_init;
            assign st_init.rem = in_rad;
            assign st_init.res = '0;
            assign st_next[k]  = sqrt_step(st_init, BIT_VAL);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k]   <= st_next[k];
                    meta_reg[k] <= in_meta;
                end
            end
        end
        else
        begin : g_rest
            assign st_next[k] = sqrt_step(st_reg[k-1], BIT_VAL);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k]   <= st_next[k];
                    meta_reg[k] <= meta_reg[k-1];
                end
            end
        end
    end

    // last stage doubles as the output register
    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_root  = st_reg[SQRT_STEPS-1].res[MAG_W-1:0];
    assign out_meta  = meta_reg[SQRT_STEPS-1];

endmodule

/* design/sobel_gradient_magnitude.sv */
// a result passes stage 1, stages 2 to 4 and the square root stages once its window is complete
// throughput: one pixel per cycle unless held; each line store takes one read and one write a cycle
// the whole pipeline holds only while a result waits at the output and is not taken
// reset: counters, window and output valids clear, frame size returns to 640 x 480
// the line stores are not cleared; entries are written before any result depends on them
module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // pixel[7:0]
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // center_row[9:0], center_col[19:10], grad_x[30:20], grad_y[41:31], magnitude[52:42]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast   // frame_last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CFG_W-1:0] WMAX = CFG_W'((MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM);
    localparam logic [CFG_W-1:0] HMAX = CFG_W'(MAX_DIM);
    localparam logic [CFG_W-1:0] DMIN = CFG_W'(MIN_DIM);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CFG_W-1:0]   w_use;
    logic [CFG_W-1:0]   h_use;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_next;
    logic               en;
    logic               accept;
    logic               row_end;
    logic               frame_end;
    logic               emit;
    logic               inner;
    logic               cfg_write;
    logic [AW-1:0]      rd_addr;

    // line stores
    logic [PIXEL_W-1:0] older_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] older_rd_reg;
    logic [PIXEL_W-1:0] newer_rd_reg;

    // stage 1: line store data returned
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_emit_reg;
    logic               s1_inner_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic               s1_last_reg;

    // window, [row 0 top][col 0 left]
    logic [PIXEL_W-1:0] win_reg  [3][3];
    logic [PIXEL_W-1:0] win_next [3][3];
    logic [GRAD_W-1:0]  sum_right;
    logic [GRAD_W-1:0]  sum_left;
    logic [GRAD_W-1:0]  sum_top;
    logic [GRAD_W-1:0]  sum_bottom;
    sgm_meta_t          s2_meta_next;

    // stage 2: gradients
    logic               s2_valid_reg;
    sgm_meta_t          s2_meta_reg;

    // stage 3: squares
    logic               s3_valid_reg;
    sgm_meta_t          s3_meta_reg;
    logic [RAD_W-1:0]   gx_sq_reg;
    logic [RAD_W-1:0]   gy_sq_reg;
    logic [2*GRAD_W-1:0] gx_sq;
    logic [2*GRAD_W-1:0] gy_sq;

    // stage 4: radicand
    logic               s4_valid_reg;
    sgm_meta_t          s4_meta_reg;
    logic [RAD_W-1:0]   rad_reg;

    logic [MAG_W-1:0]   mag;
    sgm_meta_t          out_meta;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(paddr[2]))
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // frame size in use
    always_comb
    begin
        if (width_reg < DMIN)
            w_use = DMIN;
        else if (width_reg > WMAX)
            w_use = WMAX;
        else
            w_use = width_reg;

        if (height_reg < DMIN)
            h_use = DMIN;
        else if (height_reg > HMAX)
            h_use = HMAX;
        else
            h_use = height_reg;
    end

    // handshake and position of the incoming pixel
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign row_end   = {1'b0, col_reg} >= (w_use - CFG_W'(1));
    assign frame_end = row_end && ({1'b0, row_reg} >= (h_use - CFG_W'(1)));
    assign emit      = (row_reg >= COORD_W'(1)) && (col_reg >= COORD_W'(1));
    assign inner     = (row_reg >= COORD_W'(2)) && (col_reg >= COORD_W'(2));
    assign rd_addr   = AW'(col_reg);

    always_comb
    begin
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + COORD_W'(1);
        end
        else
        begin
            col_next = col_reg + COORD_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: read on the transaction, written back from the stage 1 registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_rd_reg <= older_mem[rd_addr];
            newer_rd_reg <= newer_mem[rd_addr];
        end
        if (en && s1_valid_reg)
        begin
            older_mem[s1_addr_reg] <= newer_rd_reg;
            newer_mem[s1_addr_reg] <= s1_pixel_reg;
        end
    end

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= s_axis_tdata[PIXEL_W-1:0];
            s1_addr_reg  <= rd_addr;
            s1_emit_reg  <= emit;
            s1_inner_reg <= inner;
            s1_row_reg   <= row_reg - COORD_W'(1);
            s1_col_reg   <= col_reg - COORD_W'(1);
            s1_last_reg  <= frame_end;
        end
    end

    // window shift and gradients
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = older_rd_reg;
        win_next[1][2] = newer_rd_reg;
        win_next[2][2] = s1_pixel_reg;

        sum_right  = GRAD_W'(win_next[0][2]) + (GRAD_W'(win_next[1][2]) << 1)
                   + GRAD_W'(win_next[2][2]);
        sum_left   = GRAD_W'(win_next[0][0]) + (GRAD_W'(win_next[1][0]) << 1)
                   + GRAD_W'(win_next[2][0]);
        sum_top    = GRAD_W'(win_next[0][0]) + (GRAD_W'(win_next[0][1]) << 1)
                   + GRAD_W'(win_next[0][2]);
        sum_bottom = GRAD_W'(win_next[2][0]) + (GRAD_W'(win_next[2][1]) << 1)
                   + GRAD_W'(win_next[2][2]);

        s2_meta_next.center_row = s1_row_reg;
        s2_meta_next.center_col = s1_col_reg;
        s2_meta_next.frame_last = s1_last_reg;
        // border centres give zero gradients
        if (s1_inner_reg)
        begin
            s2_meta_next.grad_x = $signed(sum_right - sum_left);
            s2_meta_next.grad_y = $signed(sum_top - sum_bottom);
        end
        else
        begin
            s2_meta_next.grad_x = '0;
            s2_meta_next.grad_y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (en && s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // stages 2 to 4: gradients, squares, radicand
    assign gx_sq = $signed(s2_meta_reg.grad_x) * $signed(s2_meta_reg.grad_x);
    assign gy_sq = $signed(s2_meta_reg.grad_y) * $signed(s2_meta_reg.grad_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_meta_reg <= s2_meta_next;
            s3_meta_reg <= s2_meta_reg;
            gx_sq_reg   <= gx_sq[RAD_W-1:0];
            gy_sq_reg   <= gy_sq[RAD_W-1:0];
            s4_meta_reg <= s3_meta_reg;
            rad_reg     <= gx_sq_reg + gy_sq_reg;
        end
    end

    // square root, last stage is the output register
    sgm_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_rad    (rad_reg),
        .in_meta   (s4_meta_reg),
        .out_valid (m_axis_tvalid),
        .out_root  (mag),
        .out_meta  (out_meta)
    );

    assign m_axis_tdata = {3'b000, mag, out_meta.grad_y, out_meta.grad_x,
                           out_meta.center_col, out_meta.center_row};
    assign m_axis_tlast = out_meta.frame_last;

    // checks
    a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input held without a waiting result");

    a_no_same_entry_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (rd_addr != s1_addr_reg))
        else $error("line store read and write hit the same entry");

    a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < MAX_WIDTH)
        else $error("column beyond line store depth");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_meta.center_row == '0 || out_meta.center_col == '0))
        |-> (out_meta.grad_x == '0 && out_meta.grad_y == '0 && mag == '0))
        else $error("border centre with nonzero gradient");

    a_zero_grad_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_meta.grad_x == '0 && out_meta.grad_y == '0) |-> (mag == '0))
        else $error("magnitude nonzero for zero gradients");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sgm_pkg::*;

    // run limit in clock cycles, far above the slowest correct run
    localparam int CYCLE_LIMIT  = 400000;
    // cycles allowed after the last awaited result before the block counts as idle
    localparam int DRAIN_CYCLES = 24;

    // one gradient result as it leaves the block
    typedef struct packed {
        logic [COORD_W-1:0]       center_row;
        logic [COORD_W-1:0]       center_col;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [MAG_W-1:0]         magnitude;
        logic                     frame_last;
    } grad_result_t;

    // one directed pixel with the result it must give, typed in
    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        bit                 has_res;
        grad_result_t       res;
    } stim_row_t;

    // pixel styles for random frames
    typedef enum int {
        PX_UNIFORM = 0,
        PX_BINARY  = 1,
        PX_SMOOTH  = 2
    } px_style_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // pixel[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // center_row[9:0], center_col[19:10], grad_x[30:20], grad_y[41:31], magnitude[52:42]
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;   // frame_last

    sobel_gradient_magnitude dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state: frame size, line stores, window and raster position
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    bit [PIXEL_W-1:0]   line_older [DEF_MAX_WIDTH];
    bit [PIXEL_W-1:0]   line_newer [DEF_MAX_WIDTH];
    int                 win [3][3];
    int unsigned        row_cnt;
    int unsigned        col_cnt;

    grad_result_t       awaited_grads [$];

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 px_base;
    int                 cycles;
    int                 mismatch_count;
    int                 pixels_sent;
    int                 results_seen;
    int                 cfg_writes;
    int                 gx_lo, gx_hi, gy_lo, gy_hi, mag_hi;
    grad_result_t       got;
    grad_result_t       want;

    // two 3x3 frames: both gradient signs, border centres and frame end
    stim_row_t directed_rows [18] = '{
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b1, '{10'd0, 10'd0, 11'sd0, 11'sd0, 11'd0, 1'b0}},
        '{8'd255, 1'b1, '{10'd0, 10'd1, 11'sd0, 11'sd0, 11'd0, 1'b0}},
        '{8'd255, 1'b0, '0},
        '{8'd255, 1'b1, '{10'd1, 10'd0, 11'sd0, 11'sd0, 11'd0, 1'b0}},
        '{8'd255, 1'b1, '{10'd1, 10'd1, 11'sd765, -11'sd765, 11'd1081, 1'b1}},
        '{8'd255, 1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd0,   1'b1, '{10'd0, 10'd0, 11'sd0, 11'sd0, 11'd0, 1'b0}},
        '{8'd0,   1'b1, '{10'd0, 10'd1, 11'sd0, 11'sd0, 11'd0, 1'b0}},
        '{8'd255, 1'b0, '0},
        '{8'd0,   1'b1, '{10'd1, 10'd0, 11'sd0, 11'sd0, 11'd0, 1'b0}},
        '{8'd0,   1'b1, '{10'd1, 10'd1, -11'sd765, 11'sd765, 11'd1081, 1'b1}}
    };

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // cycle count and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // floor of the square root, one result bit at a time from the top
    function automatic int unsigned int_sqrt(input int unsigned v);
        int unsigned root;
        int unsigned trial;
        int          b;
        root = 0;
        for (b = 10; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // advance the predictor by one pixel and give the result it completes, if any
    function automatic void compute_sobel(input logic [PIXEL_W-1:0] px, output bit emit,
                                          output grad_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned crow;
        int unsigned ccol;
        int          gx;
        int          gy;
        int          r;
        bit [7:0]    top;
        bit [7:0]    mid;
        bit          row_end;
        bit          frame_end;
        w   = clamp_dim(width_reg, (DEF_MAX_WIDTH < MAX_DIM) ? DEF_MAX_WIDTH : MAX_DIM);
        h   = clamp_dim(height_reg, MAX_DIM);
        col = col_cnt;
        row = row_cnt;

        // line stores: read the two rows above, shift them down
        top = line_older[col];
        mid = line_newer[col];
        line_older[col] = mid;
        line_newer[col] = px;

        // window moves one column left
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        row_end   = (col >= w - 1);
        frame_end = row_end && (row >= h - 1);
        emit      = (row >= 1) && (col >= 1);
        res       = '0;

        if (emit)
        begin
            crow = row - 1;
            ccol = col - 1;
            gx   = 0;
            gy   = 0;
            // border centres keep zero gradients
            if (crow != 0 && ccol != 0)
            begin
                gx = (win[0][2] + 2 * win[1][2] + win[2][2])
                   - (win[0][0] + 2 * win[1][0] + win[2][0]);
                gy = (win[0][0] + 2 * win[0][1] + win[0][2])
                   - (win[2][0] + 2 * win[2][1] + win[2][2]);
                res.magnitude = MAG_W'(int_sqrt(gx * gx + gy * gy));
            end
            res.center_row = COORD_W'(crow);
            res.center_col = COORD_W'(ccol);
            res.grad_x     = GRAD_W'(gx);
            res.grad_y     = GRAD_W'(gy);
            res.frame_last = frame_end;
        end

        // raster position
        if (row_end)
        begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : ((row + 1) & 32'h3FF);
        end
        else
        begin
            col_cnt = (col + 1) & 32'h3FF;
        end
    endfunction

    function automatic logic [PIXEL_W-1:0] next_pixel(input px_style_t style);
        case (style)
            PX_BINARY: return $urandom_range(1) ? 8'd255 : 8'd0;
            PX_SMOOTH: return PIXEL_W'(px_base + $urandom_range(15));
            default:   return PIXEL_W'($urandom_range(255));
        endcase
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_val,
                               input logic signed [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.center_row = m_axis_tdata[9:0];
            got.center_col = m_axis_tdata[19:10];
            got.grad_x     = m_axis_tdata[30:20];
            got.grad_y     = m_axis_tdata[41:31];
            got.magnitude  = m_axis_tdata[52:42];
            got.frame_last = m_axis_tlast;
            results_seen++;
            if (awaited_grads.size() == 0)
            begin
                $error("result for row %0d col %0d with none awaited",
                       got.center_row, got.center_col);
                mismatch_count++;
            end
            else
            begin
                want = awaited_grads.pop_front();
                check_field("center_row", want.center_row, got.center_row);
                check_field("center_col", want.center_col, got.center_col);
                check_field("grad_x", want.grad_x, got.grad_x);
                check_field("grad_y", want.grad_y, got.grad_y);
                check_field("magnitude", want.magnitude, got.magnitude);
                check_field("frame_last", want.frame_last, got.frame_last);
                if (want.grad_x < gx_lo) gx_lo = want.grad_x;
                if (want.grad_x > gx_hi) gx_hi = want.grad_x;
                if (want.grad_y < gy_lo) gy_lo = want.grad_y;
                if (want.grad_y > gy_hi) gy_hi = want.grad_y;
                if (want.magnitude > mag_hi) mag_hi = want.magnitude;
            end
        end
    end

    // one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit typed, input bit typed_has,
                              input grad_result_t typed_res);
        bit           emit;
        grad_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
        compute_sobel(px, emit, res);
        if (typed)
        begin
            if (typed_has)
                awaited_grads.push_back(typed_res);
        end
        else if (emit)
        begin
            awaited_grads.push_back(res);
        end
    endtask

    // pixels until the raster position wraps to the frame start
    task automatic send_frame(input px_style_t style);
        do
            send_pixel(next_pixel(style), 1'b0, 1'b0, '0);
        while (row_cnt != 0 || col_cnt != 0);
    endtask

    // stop the stream and let every awaited result and the pipeline drain
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_grads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb setup and access cycles
    task automatic apb_access(input bit wr, input cfg_reg_t r, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_write(input cfg_reg_t r, input int unsigned value);
        logic [31:0] wdata;
        logic [31:0] unused;
        // upper bits random, only the low 11 are kept
        wdata        = $urandom();
        wdata[10:0]  = value[10:0];
        apb_access(1'b1, r, wdata, unused);
        if (r == REG_FRAME_WIDTH)
            width_reg = value[10:0];
        else
            height_reg = value[10:0];
        cfg_writes++;
    endtask

    task automatic check_reg(input cfg_reg_t r, input logic [31:0] exp_val);
        logic [31:0] rdata;
        apb_access(1'b0, r, '0, rdata);
        check_field(r.name(), exp_val, rdata);
    endtask

    task automatic apply_cfg(input int unsigned w, input int unsigned h);
        reg_write(REG_FRAME_WIDTH, w);
        reg_write(REG_FRAME_HEIGHT, h);
        check_reg(REG_FRAME_WIDTH, {21'b0, width_reg});
        check_reg(REG_FRAME_HEIGHT, {21'b0, height_reg});
    endtask

    // whole frames of random small sizes, out-of-range register values among them
    task automatic run_small_frames(input int budget);
        int          first;
        int unsigned w;
        int unsigned h;
        px_style_t   style;
        first = pixels_sent;
        while (pixels_sent - first < budget)
        begin
            case ($urandom_range(9))
                0:       w = $urandom_range(2);
                1:       w = MIN_DIM;
                default: w = $urandom_range(4, 16);
            endcase
            case ($urandom_range(9))
                0:       h = $urandom_range(2);
                1:       h = MIN_DIM;
                default: h = $urandom_range(4, 10);
            endcase
            wait_idle();
            apply_cfg(w, h);
            style   = px_style_t'($urandom_range(2));
            px_base = $urandom_range(240);
            repeat ($urandom_range(1, 3)) send_frame(style);
        end
    endtask

    // main sequence
    initial
    begin
        int phase;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        width_reg      = RESET_WIDTH;
        height_reg     = RESET_HEIGHT;
        row_cnt        = 0;
        col_cnt        = 0;
        win            = '{default: 0};
        cycles         = 0;
        mismatch_count = 0;
        pixels_sent    = 0;
        results_seen   = 0;
        cfg_writes     = 0;
        gx_lo          = 0;
        gx_hi          = 0;
        gy_lo          = 0;
        gy_hi          = 0;
        mag_hi         = 0;
        px_base        = 0;
        send_idle_pct  = 12;
        recv_stall_pct = 77;

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register values after reset
        check_reg(REG_FRAME_WIDTH, {21'b0, RESET_WIDTH});
        check_reg(REG_FRAME_HEIGHT, {21'b0, RESET_HEIGHT});

        // directed frames: width below range clamps to the minimum
        apply_cfg(2, MIN_DIM);
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, 1'b1, directed_rows[i].has_res, directed_rows[i].res);

        // random phases with different idling on each side
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 77;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 12;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            run_small_frames(650);
            wait_idle();
            case (phase)
                // widest row: all register bits set, clamps to the largest width
                0:
                begin
                    apply_cfg(2047, MIN_DIM);
                    send_frame(PX_BINARY);
                end
                // tallest frame, row counter runs to its top
                1:
                begin
                    apply_cfg(MIN_DIM, MAX_DIM);
                    send_frame(PX_UNIFORM);
                end
                // registers changed in the middle of a frame, width and height both shrink
                default:
                begin
                    apply_cfg(9, 7);
                    repeat (30) send_pixel(next_pixel(PX_UNIFORM), 1'b0, 1'b0, '0);
                    wait_idle();
                    reg_write(REG_FRAME_WIDTH, 5);
                    reg_write(REG_FRAME_HEIGHT, 5);
                    send_frame(PX_BINARY);
                end
            endcase
        end

        // drain and report
        wait_idle();
        $display("%0d pixels sent, %0d gradient results checked, %0d register writes",
                 pixels_sent, results_seen, cfg_writes);
        $display("grad_x %0d..%0d, grad_y %0d..%0d, peak magnitude %0d",
                 gx_lo, gx_hi, gy_lo, gy_hi, mag_hi);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sobel_gradient_magnitude.f */
design/sgm_pkg.sv
design/sgm_sqrt_pipe.sv
design/sobel_gradient_magnitude.sv
dv/testbench.sv
